### design/dsh_pkg.sv
// Shared types, constants and the level scale table of the diamond-square height map core.
package dsh_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int ORDER_W = 4;
    localparam int WORD_W = 16;
    localparam int COORD_OUT_W = 9;
    localparam int HEIGHT_W = 8;
    localparam int LEVEL_W = 5;
    localparam int LEVEL_MAX = 31;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;
    localparam logic [HEIGHT_W-1:0] CORNER_MOD = 8'd100;
    localparam int RECIP_W = 17;
    localparam logic [RECIP_W-1:0] CORNER_RECIP = 17'd83887;
    localparam int CORNER_SHIFT = 23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        PH_CORNER,
        PH_DIAMOND,
        PH_SQUARE
    } phase_t;

    function automatic logic [HEIGHT_W-1:0] scale_of(input logic [LEVEL_W-1:0] lvl);
        logic [HEIGHT_W-1:0] s;
        unique case (lvl)
            5'd0: s = 8'd200;
            5'd1: s = 8'd151;
            5'd2: s = 8'd114;
            5'd3: s = 8'd86;
            5'd4: s = 8'd65;
            5'd5: s = 8'd49;
            5'd6: s = 8'd37;
            5'd7: s = 8'd28;
            5'd8: s = 8'd21;
            5'd9: s = 8'd15;
            5'd10: s = 8'd11;
            5'd11: s = 8'd8;
            5'd12: s = 8'd6;
            5'd13: s = 8'd4;
            5'd14: s = 8'd3;
            5'd15: s = 8'd2;
            5'd16: s = 8'd1;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

### design/dsh_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module dsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/diamond_square_heightmap_core.sv
// Top level of the diamond-square height map core: walk, neighbor reads, modulo unit, output.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  cfg     | cfg_valid/cfg_ready | grid_order
//  in      | in_valid/in_ready   | random_word
//  out     | out_valid/out_ready | pixel_x, pixel_y, height_value, frame_done
//
// Each item runs through the bit-serial modulo unit, and up to four neighbor reads of
// the grid memory overlap with it.
// A new item is taken only when the previous one has left the busy states.
// A stalled output holds the write-back state until the result register is free.
// Reset clears the walk and the control state only; the grid memory holds no defined contents after reset.
module diamond_square_heightmap_core #(
    parameter int MAX_ORDER = dsh_pkg::MAX_ORDER_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsh_pkg::ORDER_W-1:0]       grid_order,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dsh_pkg::WORD_W-1:0]        random_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dsh_pkg::COORD_OUT_W-1:0]   pixel_x,
    output logic [dsh_pkg::COORD_OUT_W-1:0]   pixel_y,
    output logic [dsh_pkg::HEIGHT_W-1:0]      height_value,
    output logic                              frame_done
);

    localparam int CW = MAX_ORDER + 1;
    localparam int SIDE_MAX = (1 << MAX_ORDER) + 1;
    localparam int DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(dsh_pkg::WORD_W + 1);
    localparam int HW = dsh_pkg::HEIGHT_W;
    localparam int PW = dsh_pkg::WORD_W + dsh_pkg::RECIP_W;

    dsh_pkg::state_t state_reg, state_next;
    dsh_pkg::phase_t phase_reg, phase_next;

    logic [dsh_pkg::ORDER_W-1:0] order_reg;
    logic [CW-1:0] span_reg, span_next;
    logic [CW-1:0] tx_reg, tx_next;
    logic [CW-1:0] ty_reg, ty_next;
    logic [1:0] sub_reg, sub_next;
    logic [dsh_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic done_next;

    logic [CW-1:0] px_reg, py_reg;
    logic [CW-1:0] nx_reg [4];
    logic [CW-1:0] ny_reg [4];
    logic [3:0] nv_reg;
    logic corner_reg, done_pend_reg;
    logic [CW-1:0] px_c, py_c;
    logic [CW-1:0] nx_c [4];
    logic [CW-1:0] ny_c [4];
    logic [3:0] nv_c;

    logic [dsh_pkg::WORD_W-1:0] word_reg;
    logic [HW-1:0] div_reg;
    logic zero_div_reg;
    logic [HW-1:0] rem_reg;
    logic [BW-1:0] bit_cnt_reg;
    logic [HW:0] rem_try;

    logic [PW-1:0] corner_prod;
    logic [dsh_pkg::WORD_W-1:0] corner_quot;
    logic [HW-1:0] corner_rem;
    logic [HW-1:0] corner_rem_reg;

    logic [2:0] rd_idx_reg;
    logic rd_vld_reg;
    logic [9:0] acc_reg;
    logic [HW-1:0] rdata;
    logic [AW-1:0] raddr, waddr;
    logic ram_we;

    logic [dsh_pkg::ORDER_W-1:0] ord_c;
    logic [CW-1:0] side, edge_c, h, stride;
    logic [CW:0] ty_sum, tx_sum;
    logic ty_wrap, tx_wrap;
    logic [CW-1:0] span_half1;

    logic [10:0] sum;
    logic [20:0] prod3;
    logic [10:0] quot;
    logic [HW-1:0] val;
    logic [2:0] ncnt;

    logic in_acc, cfg_acc, busy_done, out_free;

    assign in_acc = in_valid && in_ready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign out_free = !out_valid || out_ready;
    assign busy_done = (bit_cnt_reg == '0) && (rd_idx_reg == 3'd4) && !rd_vld_reg;

    // Grid geometry.
    always_comb
    begin
        ord_c = order_reg;
        if (ord_c == '0)
        begin
            ord_c = 4'd1;
        end
        if (int'(ord_c) > MAX_ORDER)
        begin
            ord_c = dsh_pkg::ORDER_W'(MAX_ORDER);
        end
        side = (CW'(1) << ord_c) + CW'(1);
        edge_c = side - CW'(1);
        h = span_reg >> 1;
        stride = span_reg - CW'(1);
        ty_sum = (CW+1)'(ty_reg) + (CW+1)'(stride);
        tx_sum = (CW+1)'(tx_reg) + (CW+1)'(stride);
        ty_wrap = ty_sum >= (CW+1)'(edge_c);
        tx_wrap = tx_sum >= (CW+1)'(edge_c);
        span_half1 = h + CW'(1);
    end

    // Point and neighbor selection for the current walk position.
    always_comb
    begin
        logic [CW-1:0] cx, cy;
        cx = tx_reg + h;
        cy = ty_reg + h;
        px_c = cx;
        py_c = cy;
        nv_c = 4'b0000;
        for (int i = 0; i < 4; i++)
        begin
            nx_c[i] = '0;
            ny_c[i] = '0;
        end
        unique case (phase_reg)
            dsh_pkg::PH_CORNER:
            begin
                px_c = sub_reg[1] ? edge_c : '0;
                py_c = sub_reg[0] ? edge_c : '0;
            end
            dsh_pkg::PH_DIAMOND:
            begin
                nx_c[0] = tx_reg;      ny_c[0] = ty_reg;
                nx_c[1] = cx + h;      ny_c[1] = ty_reg;
                nx_c[2] = tx_reg;      ny_c[2] = cy + h;
                nx_c[3] = cx + h;      ny_c[3] = cy + h;
                nv_c = 4'b1111;
            end
            default:
            begin
                unique case (sub_reg)
                    2'd0: begin px_c = tx_reg; py_c = cy; end
                    2'd1: begin px_c = cx + h; py_c = cy; end
                    2'd2: begin px_c = cx; py_c = ty_reg; end
                    default: begin px_c = cx; py_c = cy + h; end
                endcase
                nx_c[0] = px_c - h;    ny_c[0] = py_c;
                nx_c[1] = px_c;        ny_c[1] = py_c - h;
                nx_c[2] = px_c + h;    ny_c[2] = py_c;
                nx_c[3] = px_c;        ny_c[3] = py_c + h;
                nv_c[0] = px_c != '0;
                nv_c[1] = py_c != '0;
                nv_c[2] = px_c < edge_c;
                nv_c[3] = py_c < edge_c;
            end
        endcase
    end

    // Walk advance for one item.
    always_comb
    begin
        phase_next = phase_reg;
        span_next = span_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        sub_next = sub_reg;
        level_next = level_reg;
        done_next = 1'b0;
        unique case (phase_reg)
            dsh_pkg::PH_CORNER:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    tx_next = '0;
                    ty_next = '0;
                    span_next = side;
                    level_next = '0;
                    phase_next = dsh_pkg::PH_DIAMOND;
                end
            end
            dsh_pkg::PH_DIAMOND:
            begin
                ty_next = ty_wrap ? '0 : CW'(ty_sum);
                if (ty_wrap)
                begin
                    tx_next = tx_wrap ? '0 : CW'(tx_sum);
                    if (tx_wrap)
                    begin
                        sub_next = '0;
                        phase_next = dsh_pkg::PH_SQUARE;
                    end
                end
            end
            default:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    ty_next = ty_wrap ? '0 : CW'(ty_sum);
                    if (ty_wrap)
                    begin
                        tx_next = tx_wrap ? '0 : CW'(tx_sum);
                        if (tx_wrap)
                        begin
                            if (level_reg != dsh_pkg::LEVEL_W'(dsh_pkg::LEVEL_MAX))
                            begin
                                level_next = level_reg + 1'b1;
                            end
                            if (span_half1 < CW'(3))
                            begin
                                done_next = 1'b1;
                                span_next = side;
                                phase_next = dsh_pkg::PH_CORNER;
                                level_next = '0;
                            end
                            else
                            begin
                                span_next = span_half1;
                                phase_next = dsh_pkg::PH_DIAMOND;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= dsh_pkg::ORDER_RESET;
            phase_reg <= dsh_pkg::PH_CORNER;
            span_reg <= CW'((1 << (int'(dsh_pkg::ORDER_RESET) > MAX_ORDER ? MAX_ORDER
                            : int'(dsh_pkg::ORDER_RESET))) + 1);
            tx_reg <= '0;
            ty_reg <= '0;
            sub_reg <= '0;
            level_reg <= '0;
        end
        else if (cfg_acc)
        begin
            order_reg <= grid_order;
            phase_reg <= dsh_pkg::PH_CORNER;
            span_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
            sub_reg <= '0;
            level_reg <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            span_reg <= (phase_reg == dsh_pkg::PH_CORNER && sub_reg != 2'd3) ? side : span_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            sub_reg <= sub_next;
            level_reg <= level_next;
        end
    end

    // Corner value by reciprocal multiplication.
    assign corner_prod = PW'(random_word) * PW'(dsh_pkg::CORNER_RECIP);
    assign corner_quot = dsh_pkg::WORD_W'(corner_prod >> dsh_pkg::CORNER_SHIFT);
    assign corner_rem = HW'(random_word - corner_quot * dsh_pkg::WORD_W'(dsh_pkg::CORNER_MOD));

    // Item snapshot and modulo unit.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= px_c;
            py_reg <= py_c;
            nx_reg <= nx_c;
            ny_reg <= ny_c;
            nv_reg <= nv_c;
            corner_reg <= phase_reg == dsh_pkg::PH_CORNER;
            done_pend_reg <= done_next;
            word_reg <= random_word;
            corner_rem_reg <= corner_rem;
            div_reg <= dsh_pkg::scale_of(level_reg);
            zero_div_reg <= (phase_reg != dsh_pkg::PH_CORNER)
                         && (dsh_pkg::scale_of(level_reg) == '0);
            rem_reg <= '0;
            acc_reg <= '0;
        end
        else if (state_reg == dsh_pkg::ST_BUSY)
        begin
            if (bit_cnt_reg != '0)
            begin
                word_reg <= word_reg << 1;
                rem_reg <= (rem_try >= (HW+1)'(div_reg)) ? HW'(rem_try - (HW+1)'(div_reg))
                         : HW'(rem_try);
            end
            if (rd_vld_reg)
            begin
                acc_reg <= acc_reg + 10'(rdata);
            end
        end
    end

    assign rem_try = {rem_reg, word_reg[dsh_pkg::WORD_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsh_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            rd_idx_reg <= 3'd4;
            rd_vld_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                bit_cnt_reg <= BW'(dsh_pkg::WORD_W);
                rd_idx_reg <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (state_reg == dsh_pkg::ST_BUSY)
            begin
                if (bit_cnt_reg != '0)
                begin
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
                if (rd_idx_reg != 3'd4)
                begin
                    rd_vld_reg <= nv_reg[rd_idx_reg[1:0]];
                    rd_idx_reg <= rd_idx_reg + 3'd1;
                end
                else
                begin
                    rd_vld_reg <= 1'b0;
                end
            end
            if (ram_we)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Height value from the accumulated neighbors, or the corner value for corner items.
    always_comb
    begin
        logic [HW-1:0] rnd;
        rnd = zero_div_reg ? '0 : rem_reg;
        ncnt = 3'(nv_reg[0]) + 3'(nv_reg[1]) + 3'(nv_reg[2]) + 3'(nv_reg[3]);
        sum = 11'(rnd) + 11'(acc_reg);
        prod3 = 21'(sum) * 21'd683;
        unique case (ncnt)
            3'd4: quot = sum >> 2;
            3'd3: quot = 11'(prod3[21-1:11]);
            3'd2: quot = sum >> 1;
            3'd1: quot = sum;
            default: quot = sum;
        endcase
        if (corner_reg)
        begin
            val = corner_rem_reg;
        end
        else
        begin
            val = (quot > 11'd255) ? 8'd255 : quot[HW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            pixel_x <= dsh_pkg::COORD_OUT_W'(px_reg);
            pixel_y <= dsh_pkg::COORD_OUT_W'(py_reg);
            height_value <= val;
            frame_done <= done_pend_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsh_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = dsh_pkg::ST_BUSY;
                end
            end
            dsh_pkg::ST_BUSY:
            begin
                if (busy_done)
                begin
                    state_next = dsh_pkg::ST_WRITE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    state_next = dsh_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cfg_ready = 1'b0;
        ram_we = 1'b0;
        unique case (state_reg)
            dsh_pkg::ST_IDLE:
            begin
                in_ready = !cfg_valid;
                cfg_ready = 1'b1;
            end
            dsh_pkg::ST_BUSY:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = out_free;
            end
        endcase
    end

    assign raddr = AW'(ny_reg[rd_idx_reg[1:0]]) * AW'(SIDE_MAX) + AW'(nx_reg[rd_idx_reg[1:0]]);
    assign waddr = AW'(py_reg) * AW'(SIDE_MAX) + AW'(px_reg);

    dsh_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_grid_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(waddr),
        .wdata(val),
        .raddr(raddr),
        .rdata(rdata)
    );

`ifndef NO_ASSERTIONS
    a_accept_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == dsh_pkg::ST_BUSY)
        else $error("accepted item did not start the busy phase");

    a_stall_holds_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsh_pkg::ST_WRITE && !out_free) |=> state_reg == dsh_pkg::ST_WRITE)
        else $error("write-back left while the result register was full");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == dsh_pkg::ST_WRITE))
        else $error("result appeared outside the write-back state");
`endif

endmodule
